// File: hw/rtl/nms_pkg.sv
`default_nettype none
package nms_pkg;

  localparam int QW      = 48;   // signed Q16.32 word
  localparam int KW      = 47;   // unsigned coefficient word
  localparam int IDXW    = 8;    // mode index width
  localparam int CNTW    = 13;   // wide enough to hold the largest mode count
  localparam int NUM_MODES_DEF = 256;
  localparam int QDEPTH_DEF    = 4;

  localparam logic [QW-1:0] QMAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [QW-1:0] QMIN = 48'h8000_0000_0000;
  localparam logic [QW-1:0] QONE = 48'h0001_0000_0000;

  localparam logic OP_STEP = 1'b0;
  localparam logic OP_INIT = 1'b1;

  typedef enum logic [2:0] {
    REG_TIME_STEP      = 3'd0,
    REG_BETA_DT2       = 3'd1,
    REG_GAMMA_DT       = 3'd2,
    REG_REST_BETA_DT2  = 3'd3,
    REG_REST_GAMMA_DT  = 3'd4,
    REG_MASS_DAMP      = 3'd5,
    REG_STIFF_DAMP     = 3'd6,
    REG_NONE           = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [KW-1:0] time_step;
    logic [KW-1:0] beta_dt2;
    logic [KW-1:0] gamma_dt;
    logic [KW-1:0] rest_beta_dt2;
    logic [KW-1:0] rest_gamma_dt;
    logic [KW-1:0] mass_damp;
    logic [KW-1:0] stiff_damp;
  } coef_t;

  typedef struct packed {
    logic            op;
    logic            in_range;
    logic [IDXW-1:0] idx;
    logic [KW-1:0]   k;
    logic [QW-1:0]   f;
  } cmd_t;

  // Saturating add or subtract of two Q16.32 words.
  function automatic logic [QW-1:0] sat_add(input logic [QW-1:0] x, input logic [QW-1:0] y,
                                            input logic sub);
    logic [QW:0] s;
    s = sub ? ({x[QW-1], x} - {y[QW-1], y}) : ({x[QW-1], x} + {y[QW-1], y});
    if (s[QW] != s[QW-1]) begin
      sat_add = s[QW] ? QMIN : QMAX;
    end else begin
      sat_add = s[QW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/nms_front.sv
`default_nettype none
module nms_front #(
  parameter int NUM_MODES = nms_pkg::NUM_MODES_DEF,
  parameter int QDEPTH    = nms_pkg::QDEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      hold,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_mode,
  input  wire logic [nms_pkg::IDXW-1:0]  in_idx,
  input  wire logic [nms_pkg::KW-1:0]    in_k,
  input  wire logic [nms_pkg::QW-1:0]    in_f,
  output logic                           cmd_valid,
  input  wire logic                      cmd_ready,
  output nms_pkg::cmd_t                  cmd
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  nms_pkg::cmd_t   q_mem [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;
  nms_pkg::cmd_t   new_cmd;
  logic            push, pop;

  // Classify the item on entry: mode index against the configured mode count.
  always_comb begin
    new_cmd.op       = in_mode;
    new_cmd.idx      = in_idx;
    new_cmd.k        = in_k;
    new_cmd.f        = in_f;
    new_cmd.in_range = (nms_pkg::CNTW'(in_idx) < nms_pkg::CNTW'(NUM_MODES));
  end

  assign in_ready  = (cnt_r != (PW+1)'(QDEPTH)) && !hold;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_mem[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= new_cmd;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/nms_mul.sv
`default_nettype none
module nms_mul (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [nms_pkg::QW-1:0]   x,
  input  wire logic [nms_pkg::QW-1:0]   y,
  output logic                          done,
  output logic [nms_pkg::QW-1:0]        res
);

  // Four 32x32 partial products, one per cycle, each registered before it
  // is added into a 96-bit accumulator preset with the rounding half.
  logic          busy_r, busy_nxt, done_r, done_nxt, neg_r, neg_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic [47:0]   a_r, a_nxt, b_r, b_nxt;
  logic [63:0]   pp_r, pp_nxt;
  logic [95:0]   acc_r, acc_nxt;
  logic [47:0]   res_r, res_nxt;
  logic [31:0]   op_a, op_b;
  logic [1:0]    prev;
  logic [95:0]   pp_sh;
  logic [63:0]   mag;
  logic [47:0]   lim, m;

  always_comb begin
    unique case (cnt_r[1:0])
      2'd0: begin op_a = a_r[31:0];              op_b = b_r[31:0];              end
      2'd1: begin op_a = a_r[31:0];              op_b = {16'b0, b_r[47:32]};    end
      2'd2: begin op_a = {16'b0, a_r[47:32]};    op_b = b_r[31:0];              end
      default: begin op_a = {16'b0, a_r[47:32]}; op_b = {16'b0, b_r[47:32]};    end
    endcase
    prev = cnt_r[1:0] - 2'd1;
    unique case (prev)
      2'd0:    pp_sh = {32'b0, pp_r};
      2'd3:    pp_sh = {pp_r[31:0], 64'b0};
      default: pp_sh = {pp_r, 32'b0};
    endcase
    mag = acc_r[95:32];
    lim = neg_r ? nms_pkg::QMIN : nms_pkg::QMAX;
    m   = (mag > {16'b0, lim}) ? lim : mag[47:0];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    pp_nxt   = pp_r;
    acc_nxt  = acc_r;
    res_nxt  = res_r;
    if (start) begin
      busy_nxt = 1'b1;
      neg_nxt  = x[47] ^ y[47];
      a_nxt    = x[47] ? (48'd0 - x) : x;
      b_nxt    = y[47] ? (48'd0 - y) : y;
      acc_nxt  = 96'h8000_0000;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r < 3'd4) begin
        pp_nxt = op_a * op_b;
      end
      if (cnt_r != 3'd0 && cnt_r < 3'd5) begin
        acc_nxt = acc_r + pp_sh;
      end
      if (cnt_r == 3'd5) begin
        res_nxt  = neg_r ? (48'd0 - m) : m;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end
      cnt_nxt = cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    pp_r  <= pp_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

// File: hw/rtl/nms_div.sv
`default_nettype none
module nms_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [nms_pkg::QW-1:0]   num,
  input  wire logic [nms_pkg::QW-1:0]   den,
  output logic                          done,
  output logic [nms_pkg::QW-1:0]        res
);

  // Restoring division, one quotient bit per cycle over the numerator
  // magnitude followed by 32 fraction bits, then a rounding step.
  logic         busy_r, busy_nxt, done_r, done_nxt, neg_r, neg_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic [79:0]  sh_r, sh_nxt, q_r, q_nxt;
  logic [47:0]  d_r, d_nxt, rem_r, rem_nxt;
  logic [47:0]  res_r, res_nxt;
  logic [48:0]  t;
  logic         ge, rnd;
  logic [80:0]  qr;
  logic [47:0]  lim;

  always_comb begin
    t   = {rem_r, sh_r[79]};
    ge  = (t >= {1'b0, d_r});
    rnd = ({rem_r, 1'b0} >= {1'b0, d_r});
    qr  = {1'b0, q_r} + 81'(rnd);
    lim = neg_r ? nms_pkg::QMIN : nms_pkg::QMAX;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    if (start) begin
      busy_nxt = 1'b1;
      neg_nxt  = num[47];
      sh_nxt   = {(num[47] ? (48'd0 - num) : num), 32'b0};
      d_nxt    = den;
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r < 7'd80) begin
        rem_nxt = ge ? 48'(t - {1'b0, d_r}) : t[47:0];
        q_nxt   = {q_r[78:0], ge};
        sh_nxt  = {sh_r[78:0], 1'b0};
        cnt_nxt = cnt_r + 7'd1;
      end else begin
        if (qr > {33'b0, lim}) begin
          res_nxt = neg_r ? nms_pkg::QMIN : nms_pkg::QMAX;
        end else begin
          res_nxt = neg_r ? (48'd0 - qr[47:0]) : qr[47:0];
        end
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    sh_r  <= sh_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

// File: hw/rtl/nms_back.sv
`default_nettype none
module nms_back #(
  parameter int NUM_MODES = nms_pkg::NUM_MODES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire nms_pkg::coef_t            coef,
  input  wire logic                      cmd_valid,
  output logic                           cmd_ready,
  input  wire nms_pkg::cmd_t             cmd,
  output logic                           clearing,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [nms_pkg::IDXW-1:0]       out_idx,
  output logic [nms_pkg::QW-1:0]         out_d,
  output logic [nms_pkg::QW-1:0]         out_v,
  output logic [nms_pkg::QW-1:0]         out_a
);

  localparam int AW = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;
  localparam int QW = nms_pkg::QW;

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_LD   = 7'b0000100,
    S_GO   = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_DIVW = 7'b1000000
  } state_t;

  // One multiply per micro-op; its product folds into one accumulator.
  typedef enum logic [3:0] {
    MOP_DT_V    = 4'd0,
    MOP_RB_A    = 4'd1,
    MOP_RG_A    = 4'd2,
    MOP_SD_K    = 4'd3,
    MOP_XI_VP   = 4'd4,
    MOP_K_DP    = 4'd5,
    MOP_GD_XI   = 4'd6,
    MOP_BD_K    = 4'd7,
    MOP_GD_AN   = 4'd8,
    MOP_BD_AN   = 4'd9
  } mop_t;

  logic [3*QW-1:0]  mem [NUM_MODES];
  logic [3*QW-1:0]  rdata_r;

  state_t           state_r, state_nxt;
  mop_t             mop_r, mop_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  nms_pkg::cmd_t    cmd_r, cmd_nxt;
  logic [QW-1:0]    d_r, d_nxt, v_r, v_nxt, a_r, a_nxt;
  logic [QW-1:0]    xi_r, xi_nxt, rhs_r, rhs_nxt, lhs_r, lhs_nxt;
  logic             ov_r, ov_nxt;
  logic [nms_pkg::IDXW-1:0] oi_r, oi_nxt;
  logic [QW-1:0]    od_r, od_nxt, ovl_r, ovl_nxt, oa_r, oa_nxt;

  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [3*QW-1:0]  wr_data;
  logic             mul_start, mul_done, div_start, div_done;
  logic [QW-1:0]    mx, my, mul_res, div_res;
  logic [QW-1:0]    kx;

  assign kx = {1'b0, cmd_r.k};

  always_comb begin
    unique case (mop_r)
      MOP_DT_V:  begin mx = {1'b0, coef.time_step};     my = v_r;  end
      MOP_RB_A:  begin mx = {1'b0, coef.rest_beta_dt2}; my = a_r;  end
      MOP_RG_A:  begin mx = {1'b0, coef.rest_gamma_dt}; my = a_r;  end
      MOP_SD_K:  begin mx = {1'b0, coef.stiff_damp};    my = kx;   end
      MOP_XI_VP: begin mx = xi_r;                       my = v_r;  end
      MOP_K_DP:  begin mx = kx;                         my = d_r;  end
      MOP_GD_XI: begin mx = {1'b0, coef.gamma_dt};      my = xi_r; end
      MOP_BD_K:  begin mx = {1'b0, coef.beta_dt2};      my = kx;   end
      MOP_GD_AN: begin mx = {1'b0, coef.gamma_dt};      my = a_r;  end
      default:   begin mx = {1'b0, coef.beta_dt2};      my = a_r;  end
    endcase
  end

  nms_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (mx),
    .y     (my),
    .done  (mul_done),
    .res   (mul_res)
  );

  nms_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (rhs_r),
    .den   (lhs_r),
    .done  (div_done),
    .res   (div_res)
  );

  always_comb begin
    state_nxt = state_r;
    mop_nxt   = mop_r;
    clr_nxt   = clr_r;
    cmd_nxt   = cmd_r;
    d_nxt     = d_r;
    v_nxt     = v_r;
    a_nxt     = a_r;
    xi_nxt    = xi_r;
    rhs_nxt   = rhs_r;
    lhs_nxt   = lhs_r;
    ov_nxt    = ov_r && !out_ready;
    oi_nxt    = oi_r;
    od_nxt    = od_r;
    ovl_nxt   = ovl_r;
    oa_nxt    = oa_r;
    cmd_ready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = AW'(cmd.idx);
    wr_en     = 1'b0;
    wr_addr   = AW'(cmd_r.idx);
    wr_data   = '0;
    mul_start = 1'b0;
    div_start = 1'b0;

    unique case (state_r)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(NUM_MODES-1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid && !ov_r) begin
          cmd_ready = 1'b1;
          cmd_nxt   = cmd;
          if (cmd.in_range) begin
            rd_en     = 1'b1;
            state_nxt = S_LD;
          end else begin
            ov_nxt  = 1'b1;
            oi_nxt  = cmd.idx;
            od_nxt  = '0;
            ovl_nxt = '0;
            oa_nxt  = '0;
          end
        end
      end
      S_LD: begin
        d_nxt = rdata_r[3*QW-1:2*QW];
        v_nxt = rdata_r[2*QW-1:QW];
        a_nxt = rdata_r[QW-1:0];
        if (cmd_r.op == nms_pkg::OP_INIT) begin
          wr_en     = 1'b1;
          wr_data   = {rdata_r[3*QW-1:QW], cmd_r.f};
          ov_nxt    = 1'b1;
          oi_nxt    = cmd_r.idx;
          od_nxt    = rdata_r[3*QW-1:2*QW];
          ovl_nxt   = rdata_r[2*QW-1:QW];
          oa_nxt    = cmd_r.f;
          state_nxt = S_IDLE;
        end else begin
          xi_nxt    = {1'b0, coef.mass_damp};
          rhs_nxt   = cmd_r.f;
          lhs_nxt   = nms_pkg::QONE;
          mop_nxt   = MOP_DT_V;
          state_nxt = S_GO;
        end
      end
      S_GO: begin
        mul_start = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (mul_done) begin
          state_nxt = S_GO;
          unique case (mop_r)
            MOP_DT_V:  begin d_nxt = nms_pkg::sat_add(d_r, mul_res, 1'b0);
                             mop_nxt = MOP_RB_A; end
            MOP_RB_A:  begin d_nxt = nms_pkg::sat_add(d_r, mul_res, 1'b0);
                             mop_nxt = MOP_RG_A; end
            MOP_RG_A:  begin v_nxt = nms_pkg::sat_add(v_r, mul_res, 1'b0);
                             mop_nxt = MOP_SD_K; end
            MOP_SD_K:  begin xi_nxt = nms_pkg::sat_add(xi_r, mul_res, 1'b0);
                             mop_nxt = MOP_XI_VP; end
            MOP_XI_VP: begin rhs_nxt = nms_pkg::sat_add(rhs_r, mul_res, 1'b1);
                             mop_nxt = MOP_K_DP; end
            MOP_K_DP:  begin rhs_nxt = nms_pkg::sat_add(rhs_r, mul_res, 1'b1);
                             mop_nxt = MOP_GD_XI; end
            MOP_GD_XI: begin lhs_nxt = nms_pkg::sat_add(lhs_r, mul_res, 1'b0);
                             mop_nxt = MOP_BD_K; end
            MOP_BD_K:  begin lhs_nxt = nms_pkg::sat_add(lhs_r, mul_res, 1'b0);
                             state_nxt = S_DIV; end
            MOP_GD_AN: begin v_nxt = nms_pkg::sat_add(v_r, mul_res, 1'b0);
                             mop_nxt = MOP_BD_AN; end
            default: begin
              d_nxt     = nms_pkg::sat_add(d_r, mul_res, 1'b0);
              wr_en     = 1'b1;
              wr_data   = {d_nxt, v_r, a_r};
              ov_nxt    = 1'b1;
              oi_nxt    = cmd_r.idx;
              od_nxt    = d_nxt;
              ovl_nxt   = v_r;
              oa_nxt    = a_r;
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_DIV: begin
        div_start = 1'b1;
        state_nxt = S_DIVW;
      end
      default: begin
        if (div_done) begin
          a_nxt     = div_res;
          mop_nxt   = MOP_GD_AN;
          state_nxt = S_GO;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
      mop_r   <= MOP_DT_V;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
      mop_r   <= mop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    d_r   <= d_nxt;
    v_r   <= v_nxt;
    a_r   <= a_nxt;
    xi_r  <= xi_nxt;
    rhs_r <= rhs_nxt;
    lhs_r <= lhs_nxt;
    oi_r  <= oi_nxt;
    od_r  <= od_nxt;
    ovl_r <= ovl_nxt;
    oa_r  <= oa_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign clearing  = (state_r == S_CLR);
  assign out_valid = ov_r;
  assign out_idx   = oi_r;
  assign out_d     = od_r;
  assign out_v     = ovl_r;
  assign out_a     = oa_r;

endmodule
`default_nettype wire

// File: hw/rtl/newmark_modal_step_unit.sv
`default_nettype none
// Channel   Direction  Handshake             Content
// in_       input      in_tvalid/in_tready   one step or init item per mode
// out_      output     out_tvalid/out_tready one result item per input item
// cfg_      input      APB write/read        seven integration coefficients
//
// A step item runs in the back end as ten Q16.32 multiplies on one shared
// unit of four 32x32 partial products and one bit-serial divider of 80
// quotient bits plus rounding. The back end takes the next item only once
// the result register has emptied. The input queue keeps taking items, until
// its QDEPTH entries are full, while the back end works or while a result
// waits for out_tready. After reset, a clearing pass over all NUM_MODES
// entries zeroes the state memory; no item is taken until it ends.
module newmark_modal_step_unit #(
  parameter int NUM_MODES = nms_pkg::NUM_MODES_DEF,
  parameter int QDEPTH    = nms_pkg::QDEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // [7:0] mode_index, [54:8] stiffness, [102:55] external_work, [103] zero
  input  wire logic [103:0]  in_tdata,
  // [0] mode
  input  wire logic [0:0]    in_tuser,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // [7:0] result_index, [55:8] displacement, [103:56] velocity,
  // [151:104] acceleration
  output logic [151:0]       out_tdata,
  input  wire logic          cfg_psel,
  input  wire logic          cfg_penable,
  input  wire logic          cfg_pwrite,
  input  wire logic [5:0]    cfg_paddr,
  input  wire logic [63:0]   cfg_pwdata,
  output logic [63:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int KW = nms_pkg::KW;

  nms_pkg::coef_t     coef_r, coef_nxt;
  nms_pkg::reg_idx_t  reg_sel;
  logic               cfg_wr;
  logic               hold, cmd_valid, cmd_ready;
  nms_pkg::cmd_t      cmd;
  logic [7:0]         out_idx;
  logic [47:0]        out_d, out_v, out_a;

  // Registers sit at byte address 8*i; the low address bits are ignored.
  assign reg_sel    = nms_pkg::reg_idx_t'(cfg_paddr[5:3]);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_wr) begin
      unique case (reg_sel)
        nms_pkg::REG_TIME_STEP:     coef_nxt.time_step     = cfg_pwdata[KW-1:0];
        nms_pkg::REG_BETA_DT2:      coef_nxt.beta_dt2      = cfg_pwdata[KW-1:0];
        nms_pkg::REG_GAMMA_DT:      coef_nxt.gamma_dt      = cfg_pwdata[KW-1:0];
        nms_pkg::REG_REST_BETA_DT2: coef_nxt.rest_beta_dt2 = cfg_pwdata[KW-1:0];
        nms_pkg::REG_REST_GAMMA_DT: coef_nxt.rest_gamma_dt = cfg_pwdata[KW-1:0];
        nms_pkg::REG_MASS_DAMP:     coef_nxt.mass_damp     = cfg_pwdata[KW-1:0];
        nms_pkg::REG_STIFF_DAMP:    coef_nxt.stiff_damp    = cfg_pwdata[KW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      nms_pkg::REG_TIME_STEP:     cfg_prdata = {17'b0, coef_r.time_step};
      nms_pkg::REG_BETA_DT2:      cfg_prdata = {17'b0, coef_r.beta_dt2};
      nms_pkg::REG_GAMMA_DT:      cfg_prdata = {17'b0, coef_r.gamma_dt};
      nms_pkg::REG_REST_BETA_DT2: cfg_prdata = {17'b0, coef_r.rest_beta_dt2};
      nms_pkg::REG_REST_GAMMA_DT: cfg_prdata = {17'b0, coef_r.rest_gamma_dt};
      nms_pkg::REG_MASS_DAMP:     cfg_prdata = {17'b0, coef_r.mass_damp};
      nms_pkg::REG_STIFF_DAMP:    cfg_prdata = {17'b0, coef_r.stiff_damp};
      default:                    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  // Front end: classifies items and queues them for the sequencer.
  nms_front #(
    .NUM_MODES (NUM_MODES),
    .QDEPTH    (QDEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .hold      (hold),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_tuser[0]),
    .in_idx    (in_tdata[7:0]),
    .in_k      (in_tdata[54:8]),
    .in_f      (in_tdata[102:55]),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // Back end: state memory, multiply and divide sequencer, result register.
  nms_back #(
    .NUM_MODES (NUM_MODES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .coef      (coef_r),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .clearing  (hold),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_idx   (out_idx),
    .out_d     (out_d),
    .out_v     (out_v),
    .out_a     (out_a)
  );

  assign out_tdata = {out_a, out_v, out_d, out_idx};

endmodule
`default_nettype wire

// File: sim/newmark_modal_step_unit_test.sv
`default_nettype none
// Testbench for the modal Newmark integrator. Items are sent on the in_
// stream and a local copy of the per-mode state predicts every result item.
// The checker compares each accepted result item field by field with the
// oldest prediction. The sender works in bursts, and the receiver stalls at
// a rate that each test sets. Coefficients are written only while the block
// is idle.
module newmark_modal_step_unit_test;
  import nms_pkg::*;

  typedef struct {
    logic [7:0]         idx;
    logic signed [47:0] disp;
    logic signed [47:0] vel;
    logic signed [47:0] accel;
  } mode_result_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  // [7:0] mode_index, [54:8] stiffness, [102:55] external_work, [103] zero
  logic [103:0]  in_tdata = '0;
  // [0] mode
  logic [0:0]    in_tuser = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  // [7:0] result_index, [55:8] displacement, [103:56] velocity,
  // [151:104] acceleration
  logic [151:0]  out_tdata;
  logic          cfg_psel = 1'b0;
  logic          cfg_penable = 1'b0;
  logic          cfg_pwrite = 1'b0;
  logic [5:0]    cfg_paddr = '0;
  logic [63:0]   cfg_pwdata = '0;
  logic [63:0]   cfg_prdata;
  logic          cfg_pready;

  newmark_modal_step_unit DUT (.*);

  always #4 clk = ~clk;

  // Local copy of the coefficients and of the per-mode state.
  logic [46:0]        coef [7];
  logic signed [47:0] mode_disp [256];
  logic signed [47:0] mode_vel [256];
  logic signed [47:0] mode_accel [256];

  mode_result_t pending_results[$];
  int errors = 0;

  // Sender burst shaping and receiver stall rate, set by each test.
  int gap_max = 0;
  int burst_left = 0;
  int stall_pct = 0;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // ---------------------------------------------------------------------
  // Fixed-point arithmetic of the predictor: 48-bit signed Q16.32, every
  // operation saturating.
  // ---------------------------------------------------------------------
  function automatic logic [127:0] magnitude(input logic signed [47:0] x);
    logic signed [48:0] e;
    e = x;
    if (e < 0) e = -e;
    magnitude = {79'd0, e};
  endfunction

  function automatic logic signed [47:0] clamp_mag(input logic neg, input logic [127:0] m);
    if (neg) begin
      if (m > 128'h8000_0000_0000) m = 128'h8000_0000_0000;
      clamp_mag = 48'(128'd0 - m);
    end else begin
      if (m > 128'h7FFF_FFFF_FFFF) m = 128'h7FFF_FFFF_FFFF;
      clamp_mag = m[47:0];
    end
  endfunction

  function automatic logic signed [47:0] q_sum(input logic signed [47:0] x,
                                               input logic signed [47:0] y, input logic sub);
    logic signed [48:0] s;
    logic signed [48:0] xe;
    logic signed [48:0] ye;
    xe = x;
    ye = y;
    s = sub ? xe - ye : xe + ye;
    if (s > 49'sh7FFF_FFFF_FFFF) q_sum = QMAX;
    else if (s < -49'sh8000_0000_0000) q_sum = QMIN;
    else q_sum = s[47:0];
  endfunction

  // Product rounded half away from zero to 32 fraction bits.
  function automatic logic signed [47:0] q_mul(input logic signed [47:0] x,
                                               input logic signed [47:0] y);
    logic [127:0] p;
    p = magnitude(x) * magnitude(y) + 128'h8000_0000;
    q_mul = clamp_mag(x[47] ^ y[47], p >> 32);
  endfunction

  // Quotient rounded half away from zero; the divisor is at least 1.0.
  function automatic logic signed [47:0] q_div(input logic signed [47:0] num,
                                               input logic signed [47:0] den);
    logic [127:0] m;
    logic [127:0] d;
    logic [127:0] q;
    logic [127:0] r;
    m = magnitude(num) << 32;
    d = {80'd0, den};
    q = m / d;
    r = m % d;
    if (2 * r >= d) q = q + 1;
    q_div = clamp_mag(num[47], q);
  endfunction

  function automatic logic signed [47:0] coef_q(input reg_idx_t r);
    coef_q = {1'b0, coef[r]};
  endfunction

  // Advances the local state by one item and returns the result it reports.
  function automatic mode_result_t predict_mode_update(input logic op, input logic [7:0] idx,
                                                       input logic [46:0] k_in,
                                                       input logic signed [47:0] force_in);
    mode_result_t res;
    logic signed [47:0] k;
    logic signed [47:0] dp;
    logic signed [47:0] vp;
    logic signed [47:0] xi;
    logic signed [47:0] rhs;
    logic signed [47:0] lhs;
    logic signed [47:0] an;
    k = {1'b0, k_in};
    if (op == OP_INIT) begin
      mode_accel[idx] = force_in;
    end else begin
      dp = q_sum(q_sum(mode_disp[idx], q_mul(coef_q(REG_TIME_STEP), mode_vel[idx]), 1'b0),
                 q_mul(coef_q(REG_REST_BETA_DT2), mode_accel[idx]), 1'b0);
      vp = q_sum(mode_vel[idx], q_mul(coef_q(REG_REST_GAMMA_DT), mode_accel[idx]), 1'b0);
      xi = q_sum(coef_q(REG_MASS_DAMP), q_mul(coef_q(REG_STIFF_DAMP), k), 1'b0);
      rhs = q_sum(q_sum(force_in, q_mul(xi, vp), 1'b1), q_mul(k, dp), 1'b1);
      lhs = q_sum(q_sum(QONE, q_mul(coef_q(REG_GAMMA_DT), xi), 1'b0),
                  q_mul(coef_q(REG_BETA_DT2), k), 1'b0);
      an = q_div(rhs, lhs);
      mode_accel[idx] = an;
      mode_vel[idx] = q_sum(vp, q_mul(coef_q(REG_GAMMA_DT), an), 1'b0);
      mode_disp[idx] = q_sum(dp, q_mul(coef_q(REG_BETA_DT2), an), 1'b0);
    end
    res.idx = idx;
    res.disp = mode_disp[idx];
    res.vel = mode_vel[idx];
    res.accel = mode_accel[idx];
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers. All of them start and end at a falling edge.
  // ---------------------------------------------------------------------
  function automatic logic [47:0] rand48();
    rand48 = 48'({$urandom(), $urandom()});
  endfunction

  task automatic send_item(input logic op, input logic [7:0] idx, input logic [46:0] k,
                           input logic [47:0] force_in);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {1'b0, force_in, k, idx};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_mode_update(op, idx, k, force_in));
    @(negedge clk);
    // Bursts of random length; a gap lowers valid for a random while.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if (gap_max > 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
      end
    end
  endtask

  // Holds the sender until every predicted result item has arrived, then
  // lets the block settle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_coef(input reg_idx_t r, input logic [46:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {r, 3'b000};
    cfg_pwdata <= {17'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    coef[r] = value;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // Writes all seven coefficients; the block must be idle.
  task automatic load_coefs(input logic [46:0] ts, input logic [46:0] bdt2,
                            input logic [46:0] gdt, input logic [46:0] rbdt2,
                            input logic [46:0] rgdt, input logic [46:0] md,
                            input logic [46:0] sd);
    wait_drained();
    write_coef(REG_TIME_STEP, ts);
    write_coef(REG_BETA_DT2, bdt2);
    write_coef(REG_GAMMA_DT, gdt);
    write_coef(REG_REST_BETA_DT2, rbdt2);
    write_coef(REG_REST_GAMMA_DT, rgdt);
    write_coef(REG_MASS_DAMP, md);
    write_coef(REG_STIFF_DAMP, sd);
  endtask

  // Physically plausible coefficients for a time step of dt (Q16.32).
  task automatic load_plausible(input logic [46:0] dt);
    logic [46:0] dt2;
    dt2 = 47'((64'(dt) * 64'(dt) + 64'h8000_0000) >> 32);
    load_coefs(dt, dt2 >> 2, dt >> 1, (dt2 >> 1) - (dt2 >> 2), dt - (dt >> 1),
               47'($urandom_range(0, 32'h4000_0000)), 47'($urandom_range(0, 32'h0100_0000)));
  endtask

  // ---------------------------------------------------------------------
  // Checker and receiver.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    out_tready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    mode_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result for mode %0d", out_tdata[7:0]));
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[7:0] !== want.idx)
          report($sformatf("result_index %0d, expected %0d", out_tdata[7:0], want.idx));
        if (out_tdata[55:8] !== want.disp)
          report($sformatf("mode %0d displacement %h, expected %h",
                           want.idx, out_tdata[55:8], want.disp));
        if (out_tdata[103:56] !== want.vel)
          report($sformatf("mode %0d velocity %h, expected %h",
                           want.idx, out_tdata[103:56], want.vel));
        if (out_tdata[151:104] !== want.accel)
          report($sformatf("mode %0d acceleration %h, expected %h",
                           want.idx, out_tdata[151:104], want.accel));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // Field extremes with the reset coefficients (divisor exactly 1.0), then
  // all coefficients at their maximum so that products, sums and the
  // divisor saturate, then all at their minimum again.
  task automatic test_directed();
    gap_max = 0;
    stall_pct = 0;
    send_item(OP_INIT, 8'd0, '1, QMAX);
    send_item(OP_INIT, 8'd255, '0, QMIN);
    send_item(OP_STEP, 8'd0, '0, 48'd0);
    send_item(OP_STEP, 8'd255, '1, QMAX);
    send_item(OP_STEP, 8'd1, '1, QMIN);
    send_item(OP_INIT, 8'd2, 47'd5, 48'hFFFF_FFFF_FFFF);
    send_item(OP_STEP, 8'd2, 47'd1, 48'd1);
    load_coefs('1, '1, '1, '1, '1, '1, '1);
    send_item(OP_STEP, 8'd0, '1, QMAX);
    send_item(OP_STEP, 8'd255, '0, QMIN);
    send_item(OP_STEP, 8'd3, 47'd1, 48'd1);
    send_item(OP_INIT, 8'd3, '0, QMAX);
    send_item(OP_STEP, 8'd3, '0, QMIN);
    send_item(OP_STEP, 8'd0, '0, 48'd0);
    load_coefs('0, '0, '0, '0, '0, '0, '0);
    send_item(OP_STEP, 8'd255, '1, 48'd0);
    send_item(OP_STEP, 8'd3, 47'h1_0000_0000, QMIN);
  endtask

  // Plausible runs: modes 0 to 7 get steps with a random stiffness and a random
  // whole-number force per item, and now and then an initial acceleration, under
  // plausible coefficients. A few items are noise with random fields on any mode.
  task automatic test_integration_runs();
    logic [7:0]  idx;
    logic [46:0] k;
    logic [47:0] force_val;
    gap_max = 6;
    stall_pct = 30;
    for (int run = 0; run < 6; run++) begin
      load_plausible(47'($urandom_range(32'h0020_0000, 32'h0800_0000)));
      for (int n = 0; n < 100; n++) begin
        idx = 8'($urandom_range(0, 7));
        k = 47'({$urandom_range(0, 4000), $urandom()});
        force_val = 48'($signed(32'($urandom_range(0, 2000)) - 1000)) << 32;
        if ($urandom_range(0, 19) == 0) send_item(OP_INIT, idx, k, force_val);
        else if ($urandom_range(0, 19) == 0) send_item(OP_STEP, 8'($urandom), 47'(rand48()),
                                                       rand48());
        else send_item(OP_STEP, idx, k, force_val);
      end
      if (run == 2) begin
        // Let everything drain mid-stream, then resume with no idling.
        wait_drained();
        gap_max = 0;
        stall_pct = 0;
      end
    end
  endtask

  // Random coefficients over their whole range and random items over the
  // whole field ranges, under heavy back pressure.
  task automatic test_random_fields();
    gap_max = 20;
    stall_pct = 60;
    for (int phase = 0; phase < 6; phase++) begin
      load_coefs(47'(rand48()), 47'(rand48()), 47'(rand48()), 47'(rand48()),
                 47'(rand48()), 47'(rand48()), 47'(rand48()));
      for (int n = 0; n < 100; n++)
        send_item(1'($urandom_range(0, 4) == 0), 8'($urandom), 47'(rand48()), rand48());
    end
  endtask

  // Small coefficients so that state grows over many steps on few modes,
  // mixed with every mode index.
  task automatic test_small_coefs();
    gap_max = 3;
    stall_pct = 10;
    for (int phase = 0; phase < 3; phase++) begin
      load_coefs(47'($urandom), 47'($urandom), 47'($urandom), 47'($urandom),
                 47'($urandom), 47'($urandom), 47'($urandom));
      for (int n = 0; n < 150; n++)
        send_item(1'($urandom_range(0, 9) == 0),
                  ($urandom_range(0, 1) == 1) ? 8'($urandom_range(250, 255)) : 8'($urandom),
                  47'({$urandom_range(0, 255), $urandom()}), rand48());
    end
  endtask

  initial begin
    for (int i = 0; i < 7; i++) coef[i] = '0;
    for (int i = 0; i < 256; i++) begin
      mode_disp[i] = '0;
      mode_vel[i] = '0;
      mode_accel[i] = '0;
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_integration_runs();
    test_random_fields();
    test_small_coefs();
    wait_drained();
    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("newmark_modal_step_unit_test: clean");
    end else begin
      $display("newmark_modal_step_unit_test: errors");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin
    #40000000;
    $display("newmark_modal_step_unit_test: errors");
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
hw/rtl/nms_pkg.sv
hw/rtl/nms_front.sv
hw/rtl/nms_mul.sv
hw/rtl/nms_div.sv
hw/rtl/nms_back.sv
hw/rtl/newmark_modal_step_unit.sv
sim/newmark_modal_step_unit_test.sv
